@@ src/hcta_pkg.sv @@
// shared constants and types for the hit to circle track assigner
package hcta_pkg;

	localparam int MAX_TRACKS  = 16;
	localparam int SLOT_W      = $clog2(MAX_TRACKS);
	localparam int TRACK_W     = 5;
	localparam int COORD_W     = 31;
	localparam int WIRE_W      = 21;
	localparam int DRIFT_W     = 15;
	localparam int COUNT_W     = 8;
	localparam int RES_W       = 32;
	localparam int SQ_W        = 64;
	localparam int ROOT_W      = SQ_W / 2;
	localparam int SQRT_STEPS  = SQ_W / 2;
	localparam int SQRT_CNT_W  = $clog2(SQRT_STEPS);

	localparam logic [TRACK_W-1:0] NO_TRACK = TRACK_W'(MAX_TRACKS);
	localparam logic [RES_W-1:0]   RES_MAX  = '1;

	// request kinds carried in tuser
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_HIT  = 1'b1;

	// register index taken from paddr
	localparam logic REG_MAX_DISTANCE = 1'b0;
	localparam logic REG_MIN_HITS     = 1'b1;

	localparam logic [31:0]        MAX_DISTANCE_RST = 32'd1024;
	localparam logic [COUNT_W-1:0] MIN_HITS_RST     = 8'd4;

	// status of the square root unit
	typedef struct packed {
		logic busy;
		logic done;
	} sqrt_sts_t;

endpackage

@@ src/hcta_sqrt.sv @@
// iterative integer square root, one result bit per cycle
module hcta_sqrt import hcta_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   radicand,
	output logic [ROOT_W-1:0] root,
	output sqrt_sts_t         sts
);

	logic [SQ_W-1:0]       v_q;
	logic [SQ_W-1:0]       r_q;
	logic [SQ_W-1:0]       bit_q;
	logic [SQRT_CNT_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [SQ_W-1:0]       trial;
	logic                  fits;

	assign trial = r_q + bit_q;
	assign fits  = (v_q >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			r_q   <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if (fits) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root     = r_q[ROOT_W-1:0];
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

@@ src/hit_to_circle_track_assigner.sv @@
// top level: track table, sequencer, shared multiplier and square root unit
//
// channel   dir  beat fields
// s_axis    in   tuser req_type; tdata slot..own_hit_count (168 bits)
// m_axis    out  tdata best_track..accept_unused (72 bits)
// apb       in   max_distance at 0x0, min_hits_prune at 0x4
//
// a load beat goes from idle to the output state, then into the output register
// a hit beat walks all 16 slots; a dead slot only passes the scan state, a live
// slot goes on through mul x, mul y, add, the 32 step square root unit and update
// s_tready is high only while the sequencer idles
// a result waits in S_OUT for a free output register, then new input is allowed
// reset clears live bits, registers and control; track data is not cleared
module hit_to_circle_track_assigner import hcta_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// slot[3:0] valid[4] center_x[35:5] center_y[66:36] radius[97:67]
	// wire_x[118:98] wire_y[139:119] drift[154:140] own_track[159:155] count[167:160]
	input  logic [167:0] s_tdata,
	// req_type[0]
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// best_track[4:0] best_residual[36:5] own_residual[68:37]
	// move_to_best[69] keep_in_own[70] accept_unused[71]
	output logic [71:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_MULX, S_MULY, S_ADD, S_SQRT, S_UPD, S_OUT
	} state_t;

	state_t state_q;

	// track table, read at the scan slot only
	logic signed [COORD_W-1:0] cx_mem [MAX_TRACKS];
	logic signed [COORD_W-1:0] cy_mem [MAX_TRACKS];
	logic        [COORD_W-1:0] rad_mem [MAX_TRACKS];
	logic        [MAX_TRACKS-1:0] live_q;

	logic [31:0]        max_distance_q;
	logic [COUNT_W-1:0] min_hits_q;

	// latched hit
	logic signed [WIRE_W-1:0] wx_q, wy_q;
	logic [DRIFT_W-1:0]       drift_q;
	logic [TRACK_W-1:0]       own_q;
	logic [COUNT_W-1:0]       count_q;
	logic                     in_track_q;

	logic [SLOT_W-1:0]  slot_q;
	logic [SQ_W-1:0]    prod_q;
	logic [SQ_W-1:0]    sumx_q;
	logic [RES_W-1:0]   res_q;
	logic [TRACK_W-1:0] best_q;
	logic [RES_W-1:0]   best_res_q;
	logic [RES_W-1:0]   own_res_q;
	logic               found_q;
	logic               out_valid_q;
	logic [71:0]        out_data_q;

	// field split of the input beat
	logic [SLOT_W-1:0]  in_slot;
	logic               in_valid;
	logic [TRACK_W-1:0] in_own;

	logic signed [31:0] dx, dy;
	logic [31:0]        ax, ay;
	logic [31:0]        mul_op;
	logic [31:0]        d1, d2;
	logic [ROOT_W-1:0]  root;
	sqrt_sts_t          sq_sts;
	logic               sq_start;
	logic               accept_in;
	logic               cfg_wr;
	logic               last_slot;
	logic               out_load;
	logic               move_c, keep_c, accept_c;

	assign in_slot  = s_tdata[SLOT_W-1:0];
	assign in_valid = s_tdata[4];
	assign in_own   = s_tdata[159:155];

	assign s_tready  = (state_q == S_IDLE);
	assign accept_in = s_tvalid && s_tready;
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_MAX_DISTANCE) ? max_distance_q
		: {{(32 - COUNT_W){1'b0}}, min_hits_q};

	// distance components against the slot under scan
	assign dx = 32'(cx_mem[slot_q]) - 32'(wx_q);
	assign dy = 32'(cy_mem[slot_q]) - 32'(wy_q);
	assign ax = dx[31] ? 32'(-dx) : 32'(dx);
	assign ay = dy[31] ? 32'(-dy) : 32'(dy);

	// the one multiplier squares x then y
	assign mul_op = (state_q == S_MULX) ? ax : ay;

	// residual ||radius - dist| - drift|
	assign d1 = ({1'b0, rad_mem[slot_q]} > root) ? {1'b0, rad_mem[slot_q]} - root
		: root - {1'b0, rad_mem[slot_q]};
	assign d2 = (d1 > 32'(drift_q)) ? d1 - 32'(drift_q) : 32'(drift_q) - d1;

	assign sq_start  = (state_q == S_ADD);
	assign last_slot = (slot_q == SLOT_W'(MAX_TRACKS - 1));

	// output register free or being emptied this cycle
	assign out_load = (state_q == S_OUT) && (!out_valid_q || m_tready);

	assign move_c   = in_track_q && found_q && (best_res_q < own_res_q);
	assign keep_c   = in_track_q && ((count_q <= min_hits_q) || (own_res_q <= max_distance_q));
	assign accept_c = !in_track_q && found_q && (best_res_q < max_distance_q);

	hcta_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sumx_q + prod_q),
		.root     (root),
		.sts      (sq_sts)
	);

	// table writes
	always_ff @(posedge clk) begin
		if (accept_in && s_tuser == REQ_LOAD) begin
			cx_mem[in_slot]  <= s_tdata[35:5];
			cy_mem[in_slot]  <= s_tdata[66:36];
			rad_mem[in_slot] <= s_tdata[97:67];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			live_q         <= '0;
			max_distance_q <= MAX_DISTANCE_RST;
			min_hits_q     <= MIN_HITS_RST;
			out_valid_q    <= 1'b0;
			in_track_q     <= 1'b0;
			found_q        <= 1'b0;
			slot_q         <= '0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == REG_MAX_DISTANCE)
					max_distance_q <= pwdata;
				else
					min_hits_q <= pwdata[COUNT_W-1:0];
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;

			case (state_q)
			S_IDLE: begin
				if (accept_in) begin
					best_q     <= NO_TRACK;
					best_res_q <= RES_MAX;
					own_res_q  <= RES_MAX;
					found_q    <= 1'b0;
					slot_q     <= '0;
					wx_q       <= s_tdata[118:98];
					wy_q       <= s_tdata[139:119];
					drift_q    <= s_tdata[154:140];
					own_q      <= in_own;
					count_q    <= s_tdata[167:160];
					if (s_tuser == REQ_LOAD) begin
						live_q[in_slot] <= in_valid;
						in_track_q      <= 1'b0;
						state_q         <= S_OUT;
					end else begin
						in_track_q <= (in_own < TRACK_W'(MAX_TRACKS))
							&& live_q[in_own[SLOT_W-1:0]];
						state_q    <= S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (live_q[slot_q]) begin
					state_q <= S_MULX;
				end else if (last_slot) begin
					state_q <= S_OUT;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
			S_MULX: begin
				prod_q  <= SQ_W'(mul_op) * SQ_W'(mul_op);
				state_q <= S_MULY;
			end
			S_MULY: begin
				sumx_q  <= prod_q;
				prod_q  <= SQ_W'(mul_op) * SQ_W'(mul_op);
				state_q <= S_ADD;
			end
			S_ADD: begin
				state_q <= S_SQRT;
			end
			S_SQRT: begin
				if (sq_sts.done) begin
					res_q   <= d2;
					state_q <= S_UPD;
				end
			end
			S_UPD: begin
				if (in_track_q && own_q == TRACK_W'(slot_q)) begin
					own_res_q <= res_q;
				end else if (!found_q || res_q < best_res_q) begin
					found_q    <= 1'b1;
					best_res_q <= res_q;
					best_q     <= TRACK_W'(slot_q);
				end
				if (last_slot) begin
					state_q <= S_OUT;
				end else begin
					slot_q  <= slot_q + 1'b1;
					state_q <= S_SCAN;
				end
			end
			S_OUT: begin
				if (out_load) begin
					out_data_q <= {accept_c, keep_c, move_c, own_res_q, best_res_q, best_q};
					state_q    <= S_IDLE;
				end
			end
			default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_idle_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !sq_sts.busy)
		else $error("square root unit busy while idle");

	a_done_in_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		sq_sts.done |-> (state_q == S_SQRT))
		else $error("square root done outside its wait state");

	a_none_max: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && best_q == NO_TRACK) |-> (best_res_q == RES_MAX))
		else $error("no best track but residual set");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_data_q[69] && out_data_q[71]))
		else $error("move and accept both raised");
`endif

endmodule
